@@ rtl/bwtrs_pkg.sv @@
package bwtrs_pkg;

  // field widths
  localparam int unsigned IDX_W = 17;
  localparam int unsigned PSI_W = 16;
  localparam int unsigned MAP_W = 8;
  localparam int unsigned ANS_W = 17;
  localparam int unsigned FN_W  = 3;

  // function codes
  localparam logic [FN_W-1:0] FN_WR_PSI   = 3'd0;
  localparam logic [FN_W-1:0] FN_WR_START = 3'd1;
  localparam logic [FN_W-1:0] FN_WR_MAP   = 3'd2;
  localparam logic [FN_W-1:0] FN_RANK     = 3'd3;
  localparam logic [FN_W-1:0] FN_SELECT   = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_MAP,
    S_LO,
    S_HI,
    S_HI2,
    S_SEARCH,
    S_FIN,
    S_PSEL,
    S_DONE
  } state_t;

  // table write enables, controller to memories
  typedef struct packed {
    logic psi_we;
    logic start_we;
    logic map_we;
  } wr_en_t;

endpackage

@@ rtl/bwtrs_mem.sv @@
module bwtrs_mem #(
  parameter int unsigned MAX_TEXT = 65536,
  parameter int unsigned ALPHABET = 256,
  localparam int unsigned PAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1,
  localparam int unsigned SAW = $clog2(ALPHABET + 1),
  localparam int unsigned MAW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1
) (
  input  logic                       clk,
  input  bwtrs_pkg::wr_en_t          we,
  input  logic [PAW-1:0]             psi_addr,
  input  logic [SAW-1:0]             start_addr,
  input  logic [MAW-1:0]             map_addr,
  input  logic [bwtrs_pkg::IDX_W-1:0] wdata,
  output logic [bwtrs_pkg::PSI_W-1:0] psi_rdata,
  output logic [bwtrs_pkg::IDX_W-1:0] start_rdata,
  output logic [bwtrs_pkg::MAP_W-1:0] map_rdata
);
  import bwtrs_pkg::*;

  logic [PSI_W-1:0] psi_mem   [MAX_TEXT];
  logic [IDX_W-1:0] start_mem [ALPHABET+1];
  logic [MAP_W-1:0] map_mem   [ALPHABET];

  // psi table, one port, registered read
  always_ff @(posedge clk) begin
    if (we.psi_we) begin
      psi_mem[psi_addr] <= wdata[PSI_W-1:0];
    end
    psi_rdata <= psi_mem[psi_addr];
  end

  // interval starts
  always_ff @(posedge clk) begin
    if (we.start_we) begin
      start_mem[start_addr] <= wdata;
    end
    start_rdata <= start_mem[start_addr];
  end

  // byte to compact symbol map
  always_ff @(posedge clk) begin
    if (we.map_we) begin
      map_mem[map_addr] <= wdata[MAP_W-1:0];
    end
    map_rdata <= map_mem[map_addr];
  end

endmodule

@@ rtl/bwtrs_ctrl.sv @@
module bwtrs_ctrl #(
  parameter int unsigned MAX_TEXT = 65536,
  parameter int unsigned ALPHABET = 256,
  localparam int unsigned PAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1,
  localparam int unsigned SAW = $clog2(ALPHABET + 1),
  localparam int unsigned MAW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bwtrs_pkg::FN_W-1:0]  func,
  input  logic [bwtrs_pkg::IDX_W-1:0] position,
  input  logic [bwtrs_pkg::IDX_W-1:0] value,
  input  logic [bwtrs_pkg::MAP_W-1:0] symbol,
  input  logic [bwtrs_pkg::IDX_W-1:0] text_length,
  output logic                        done,
  output logic [bwtrs_pkg::ANS_W-1:0] answer,
  output bwtrs_pkg::wr_en_t           we,
  output logic [PAW-1:0]              psi_addr,
  output logic [SAW-1:0]              start_addr,
  output logic [MAW-1:0]              map_addr,
  output logic [bwtrs_pkg::IDX_W-1:0] wdata,
  input  logic [bwtrs_pkg::PSI_W-1:0] psi_rdata,
  input  logic [bwtrs_pkg::IDX_W-1:0] start_rdata,
  input  logic [bwtrs_pkg::MAP_W-1:0] map_rdata
);
  import bwtrs_pkg::*;

  localparam logic [31:0] MAX_TEXT_W = 32'(MAX_TEXT);
  localparam logic [31:0] ALPHA_W    = 32'(ALPHABET);

  state_t           state, state_next;
  logic [FN_W-1:0]  fn, fn_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [IDX_W-1:0] val, val_next;
  logic [MAP_W-1:0] sym, sym_next;
  logic [MAP_W-1:0] cc, cc_next;
  logic [IDX_W-1:0] lo, lo_next;
  logic [IDX_W-1:0] hi, hi_next;
  logic [IDX_W-1:0] first, first_next;
  logic [IDX_W-1:0] mid, mid_next;
  logic [ANS_W-1:0] ans, ans_next;
  logic             psi_oor, psi_oor_next;
  logic [IDX_W:0]   psi_idx;

  // psi word as the search sees it: beyond the table reads zero
  logic [PSI_W-1:0] psi_val;
  logic             absent;
  logic             ge;
  logic [IDX_W:0]   sum_lo_mid, sum_mid_hi, sum_lo_hi, sel_idx;
  logic             cont_lo, cont_hi;

  assign psi_val = psi_oor ? '0 : psi_rdata;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    fn      <= fn_next;
    pos     <= pos_next;
    val     <= val_next;
    sym     <= sym_next;
    cc      <= cc_next;
    lo      <= lo_next;
    hi      <= hi_next;
    first   <= first_next;
    mid     <= mid_next;
    ans     <= ans_next;
    psi_oor <= psi_oor_next;
  end

  // datapath helpers
  always_comb begin
    absent = ({24'd0, sym} >= ALPHA_W) || ((map_rdata == '0) && (sym != '0))
             || ({24'd0, map_rdata} >= ALPHA_W);
    ge         = {1'b0, psi_val} >= pos;
    sum_lo_mid = {1'b0, lo} + {1'b0, mid};
    sum_mid_hi = {1'b0, mid} + {1'b0, hi};
    sum_lo_hi  = {1'b0, lo} + {1'b0, start_rdata};
    sel_idx    = {1'b0, lo} + {1'b0, pos} - (IDX_W+1)'(1);
    cont_lo    = ({1'b0, lo} + (IDX_W+1)'(1)) < {1'b0, mid};
    cont_hi    = ({1'b0, mid} + (IDX_W+1)'(1)) < {1'b0, hi};
  end

  // next state, memory requests, result
  always_comb begin
    state_next = state;
    fn_next    = fn;
    pos_next   = pos;
    val_next   = val;
    sym_next   = sym;
    cc_next    = cc;
    lo_next    = lo;
    hi_next    = hi;
    first_next = first;
    mid_next   = mid;
    ans_next   = ans;
    psi_idx    = {1'b0, pos};
    start_addr = SAW'(pos);
    map_addr   = MAW'(pos);
    we         = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          fn_next  = func;
          pos_next = position;
          val_next = value;
          sym_next = symbol;
          if (func == FN_RANK || func == FN_SELECT) begin
            state_next = S_MAP;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        // out-of-range writes and unused codes change nothing
        we.psi_we   = (fn == FN_WR_PSI) && ({15'd0, pos} < MAX_TEXT_W);
        we.start_we = (fn == FN_WR_START) && ({15'd0, pos} < ALPHA_W + 32'd1);
        we.map_we   = (fn == FN_WR_MAP) && ({15'd0, pos} < ALPHA_W);
        ans_next    = '0;
        state_next  = S_DONE;
      end
      S_MAP: begin
        map_addr   = MAW'(sym);
        state_next = S_LO;
      end
      S_LO: begin
        // map word arrives; fetch interval start
        cc_next    = map_rdata;
        start_addr = SAW'(map_rdata);
        if (absent) begin
          ans_next   = (fn == FN_RANK) ? '0 : text_length;
          state_next = S_DONE;
        end else begin
          state_next = S_HI;
        end
      end
      S_HI: begin
        lo_next    = start_rdata;
        start_addr = SAW'({1'b0, cc} + 9'd1);
        state_next = S_HI2;
      end
      S_HI2: begin
        hi_next    = start_rdata;
        first_next = lo;
        if (fn == FN_RANK) begin
          if (start_rdata <= lo) begin
            ans_next   = '0;
            state_next = S_DONE;
          end else if (({1'b0, lo} + (IDX_W+1)'(1)) < {1'b0, start_rdata}) begin
            mid_next   = sum_lo_hi[IDX_W:1];
            psi_idx    = {1'b0, sum_lo_hi[IDX_W:1]};
            state_next = S_SEARCH;
          end else begin
            psi_idx    = {1'b0, lo};
            state_next = S_FIN;
          end
        end else begin
          if ((pos == '0) || (sel_idx >= {1'b0, start_rdata})) begin
            ans_next   = text_length;
            state_next = S_DONE;
          end else begin
            psi_idx    = sel_idx;
            state_next = S_PSEL;
          end
        end
      end
      S_SEARCH: begin
        // psi[mid] arrives; narrow and issue the next probe in the same cycle
        if (ge) begin
          hi_next = mid;
          if (cont_lo) begin
            mid_next = sum_lo_mid[IDX_W:1];
            psi_idx  = {1'b0, sum_lo_mid[IDX_W:1]};
          end else begin
            psi_idx    = {1'b0, lo};
            state_next = S_FIN;
          end
        end else begin
          lo_next = mid;
          if (cont_hi) begin
            mid_next = sum_mid_hi[IDX_W:1];
            psi_idx  = {1'b0, sum_mid_hi[IDX_W:1]};
          end else begin
            psi_idx    = {1'b0, mid};
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (lo > first) begin
          ans_next = ANS_W'(lo - first + IDX_W'(1));
        end else begin
          ans_next = ({1'b0, psi_val} < pos) ? ANS_W'(1) : '0;
        end
        state_next = S_DONE;
      end
      S_PSEL: begin
        ans_next   = ANS_W'(psi_val);
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    psi_oor_next = {14'd0, psi_idx} >= MAX_TEXT_W;
  end

  assign psi_addr = PAW'(psi_idx);
  assign wdata    = val;
  assign busy     = (state != S_IDLE);
  assign done     = (state == S_DONE);
  assign answer   = ans;

`ifndef SYNTH
  // a probe always lies strictly inside the open search window
  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> ((lo < mid) && (mid < hi)))
    else $error("search probe outside window");

  // table writes only in the write step, never two tables at once
  a_we_only_write: assert property (@(posedge clk) disable iff (rst)
    ($countones(we) != 0) |-> ((state == S_WRITE) && $onehot(we)))
    else $error("table write outside write step");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held more than one cycle");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word dropped");
`endif

endmodule

@@ rtl/bwt_rank_select_by_psi.sv @@
// Write words: the write step writes the table, then the result strobe follows.
// Select: map, interval bounds, psi read; an empty slot or absent symbol ends early.
// Rank: map, interval bounds, then binary search probes, at most ceil(log2) of the
// interval size (16 for 65536 entries); empty interval or absent symbol ends early.
// One dependent psi read per cycle; a new word is accepted the cycle after the strobe.
// Reset clears the sequencer and text_length; tables keep contents, written before use.
module bwt_rank_select_by_psi #(
  parameter int unsigned MAX_TEXT = 65536,
  parameter int unsigned ALPHABET = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bwtrs_pkg::FN_W-1:0]  func,
  input  logic [bwtrs_pkg::IDX_W-1:0] position,
  input  logic [bwtrs_pkg::IDX_W-1:0] value,
  input  logic [bwtrs_pkg::MAP_W-1:0] symbol,
  output logic                        done,
  output logic [bwtrs_pkg::ANS_W-1:0] answer,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bwtrs_pkg::IDX_W-1:0] cfg_data
);
  import bwtrs_pkg::*;

  localparam int unsigned PAW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int unsigned SAW = $clog2(ALPHABET + 1);
  localparam int unsigned MAW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  logic [IDX_W-1:0] text_length;
  wr_en_t           we;
  logic [PAW-1:0]   psi_addr;
  logic [SAW-1:0]   start_addr;
  logic [MAW-1:0]   map_addr;
  logic [IDX_W-1:0] wdata;
  logic [PSI_W-1:0] psi_rdata;
  logic [IDX_W-1:0] start_rdata;
  logic [MAP_W-1:0] map_rdata;

  // text length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      text_length <= cfg_data;
    end
  end

  bwtrs_ctrl #(
    .MAX_TEXT (MAX_TEXT),
    .ALPHABET (ALPHABET)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .position    (position),
    .value       (value),
    .symbol      (symbol),
    .text_length (text_length),
    .done        (done),
    .answer      (answer),
    .we          (we),
    .psi_addr    (psi_addr),
    .start_addr  (start_addr),
    .map_addr    (map_addr),
    .wdata       (wdata),
    .psi_rdata   (psi_rdata),
    .start_rdata (start_rdata),
    .map_rdata   (map_rdata)
  );

  bwtrs_mem #(
    .MAX_TEXT (MAX_TEXT),
    .ALPHABET (ALPHABET)
  ) u_mem (
    .clk         (clk),
    .we          (we),
    .psi_addr    (psi_addr),
    .start_addr  (start_addr),
    .map_addr    (map_addr),
    .wdata       (wdata),
    .psi_rdata   (psi_rdata),
    .start_rdata (start_rdata),
    .map_rdata   (map_rdata)
  );

endmodule
